>>> rtl/core/dbt_pkg.sv
// Shared types, token kinds and character classes for the byte tokenizer.
package dbt_pkg;

    // Token kinds
    localparam logic [4:0] KIND_IDENT  = 5'd12;
    localparam logic [4:0] KIND_NUMBER = 5'd13;
    localparam logic [4:0] KIND_FN     = 5'd14;
    localparam logic [4:0] KIND_LET    = 5'd15;
    localparam logic [4:0] KIND_TENSOR = 5'd16;
    localparam logic [4:0] KIND_ARROW  = 5'd17;
    localparam logic [4:0] KIND_F32    = 5'd18;
    localparam logic [4:0] KIND_I32    = 5'd19;
    localparam logic [4:0] KIND_CONST  = 5'd20;
    localparam logic [4:0] KIND_EOF    = 5'd21;

    // Characters with a role of their own
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_GT    = 8'h3E;

    // Keyword spellings, last byte in the low bits
    localparam logic [47:0] KW_FN     = 48'h0000_0000_666E;
    localparam logic [47:0] KW_LET    = 48'h0000_006C_6574;
    localparam logic [47:0] KW_TENSOR = 48'h7465_6E73_6F72;
    localparam logic [47:0] KW_F32    = 48'h0000_0066_3332;
    localparam logic [47:0] KW_I32    = 48'h0000_0069_3332;
    localparam logic [47:0] KW_CONST  = 48'h0063_6F6E_7374;

    typedef enum logic [4:0] {
        MODE_IDLE    = 5'b00001,
        MODE_IDENT   = 5'b00010,
        MODE_NUMBER  = 5'b00100,
        MODE_DASH    = 5'b01000,
        MODE_COMMENT = 5'b10000
    } mode_t;

    typedef struct packed {
        logic [7:0] byte_req;
        logic       end_of_input;
    } in_t;

    typedef struct packed {
        logic [4:0]  kind;
        logic [15:0] start_res;
        logic [15:0] length;
        logic        last;
    } out_t;

    // Results of one word, handed from the scanner to the result queue
    typedef struct packed {
        logic [1:0] count;
        out_t       first;
        out_t       second;
    } scan_res_t;

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= 8'h30) && (b <= 8'h39);
    endfunction

    function automatic logic ident_cont(input logic [7:0] b);
        return is_digit(b) || ((b >= 8'h61) && (b <= 8'h7A)) ||
               ((b >= 8'h41) && (b <= 8'h5A)) || (b == 8'h5F);
    endfunction

    // Punctuator lookup: bit 4 is hit, low bits the kind
    function automatic logic [4:0] punct_lookup(input logic [7:0] b);
        logic [4:0] r;
        case (b)
            8'h28:   r = {1'b1, 4'd0};
            8'h29:   r = {1'b1, 4'd1};
            8'h2C:   r = {1'b1, 4'd2};
            8'h3C:   r = {1'b1, 4'd3};
            8'h3E:   r = {1'b1, 4'd4};
            8'h3A:   r = {1'b1, 4'd5};
            8'h3B:   r = {1'b1, 4'd6};
            8'h7B:   r = {1'b1, 4'd7};
            8'h7D:   r = {1'b1, 4'd8};
            8'h5B:   r = {1'b1, 4'd9};
            8'h5D:   r = {1'b1, 4'd10};
            8'h3D:   r = {1'b1, 4'd11};
            default: r = 5'd0;
        endcase
        return r;
    endfunction

    // Keyword kind; short_len says the length fits in len3
    function automatic logic [4:0] kw_kind(input logic [47:0] kbuf,
                                           input logic        short_len,
                                           input logic [2:0]  len3);
        logic [4:0] k;
        k = KIND_IDENT;
        if (short_len)
        begin
            if (len3 == 3'd2 && kbuf == KW_FN)     k = KIND_FN;
            if (len3 == 3'd3 && kbuf == KW_LET)    k = KIND_LET;
            if (len3 == 3'd6 && kbuf == KW_TENSOR) k = KIND_TENSOR;
            if (len3 == 3'd3 && kbuf == KW_F32)    k = KIND_F32;
            if (len3 == 3'd3 && kbuf == KW_I32)    k = KIND_I32;
            if (len3 == 3'd5 && kbuf == KW_CONST)  k = KIND_CONST;
        end
        return k;
    endfunction

endpackage

>>> rtl/core/dbt_scan.sv
// Scanner: token state and the up to two results that one source word causes.
module dbt_scan #(
    parameter int POSITION_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  dbt_pkg::in_t      word,
    output dbt_pkg::scan_res_t res
);

    localparam int PB = POSITION_BITS;

    dbt_pkg::mode_t    mode_reg, mode_next;
    logic [PB-1:0]     pos_reg, pos_next;
    logic [PB-1:0]     start_reg, start_next;
    logic [47:0]       kbuf_reg, kbuf_next;

    logic [7:0]        b;
    logic              eof;
    logic [PB-1:0]     diff;
    logic [PB+15:0]    diff_ext;
    logic [PB+15:0]    pos_ext;
    logic [PB+15:0]    start_ext;
    logic [15:0]       tok_len;
    logic              short_len;
    logic [4:0]        punct;

    assign b         = word.byte_req;
    assign eof       = word.end_of_input || (b == dbt_pkg::CH_NUL);
    assign diff      = pos_reg - start_reg;
    assign diff_ext  = {16'd0, diff};
    assign pos_ext   = {16'd0, pos_reg};
    assign start_ext = {16'd0, start_reg};
    // Saturate the length to 16 bits
    assign tok_len   = (|diff_ext[PB+15:16]) ? 16'hFFFF : diff_ext[15:0];
    assign short_len = (diff_ext[PB+15:3] == '0);
    assign punct     = dbt_pkg::punct_lookup(b);

    // Walk the word through the open token, then through the idle rules
    always_comb
    begin
        logic done;
        logic [4:0] k;
        logic [15:0] s;
        logic [15:0] l;
        logic want;

        mode_next  = mode_reg;
        start_next = start_reg;
        kbuf_next  = kbuf_reg;
        pos_next   = eof ? '0 : pos_reg + PB'(1);
        res        = '0;
        done       = 1'b0;
        want       = 1'b0;
        k          = '0;
        s          = '0;
        l          = '0;

        if (mode_next == dbt_pkg::MODE_COMMENT)
        begin
            if (!eof)
            begin
                if (b == dbt_pkg::CH_LF)
                    mode_next = dbt_pkg::MODE_IDLE;
                done = 1'b1;
            end
            else
                mode_next = dbt_pkg::MODE_IDLE;
        end

        if (!done && mode_next == dbt_pkg::MODE_DASH)
        begin
            if (!eof && b == dbt_pkg::CH_DASH)
            begin
                mode_next = dbt_pkg::MODE_COMMENT;
                done = 1'b1;
            end
            else if (!eof && b == dbt_pkg::CH_GT)
            begin
                res.count = 2'd1;
                res.first = '{kind: dbt_pkg::KIND_ARROW, start_res: start_ext[15:0],
                              length: 16'd2, last: 1'b1};
                mode_next = dbt_pkg::MODE_IDLE;
                done = 1'b1;
            end
            else
                mode_next = dbt_pkg::MODE_IDENT;
        end

        // Close or extend an identifier or a number
        if (!done)
        begin
            if (mode_next == dbt_pkg::MODE_IDENT)
            begin
                if (!eof && dbt_pkg::ident_cont(b))
                begin
                    kbuf_next = {kbuf_reg[39:0], b};
                    done = 1'b1;
                end
                else
                begin
                    res.count = 2'd1;
                    res.first = '{kind: dbt_pkg::kw_kind(kbuf_reg, short_len, diff_ext[2:0]),
                                  start_res: start_ext[15:0], length: tok_len, last: 1'b0};
                    mode_next = dbt_pkg::MODE_IDLE;
                end
            end
            else if (mode_next == dbt_pkg::MODE_NUMBER)
            begin
                if (!eof && (dbt_pkg::is_digit(b) || b == 8'h2E))
                    done = 1'b1;
                else
                begin
                    res.count = 2'd1;
                    res.first = '{kind: dbt_pkg::KIND_NUMBER, start_res: start_ext[15:0],
                                  length: tok_len, last: 1'b0};
                    mode_next = dbt_pkg::MODE_IDLE;
                end
            end
        end

        // Handle the word as the start of something new
        if (!done)
        begin
            if (eof)
            begin
                want       = 1'b1;
                k          = dbt_pkg::KIND_EOF;
                s          = pos_ext[15:0];
                l          = 16'd0;
                mode_next  = dbt_pkg::MODE_IDLE;
                start_next = '0;
                kbuf_next  = '0;
            end
            else if (b == dbt_pkg::CH_SPACE || b == dbt_pkg::CH_TAB || b == dbt_pkg::CH_LF)
            begin
                mode_next = dbt_pkg::MODE_IDLE;
            end
            else if (b == dbt_pkg::CH_DASH)
            begin
                mode_next  = dbt_pkg::MODE_DASH;
                start_next = pos_reg;
                kbuf_next  = {40'd0, b};
            end
            else if (dbt_pkg::is_digit(b))
            begin
                mode_next  = dbt_pkg::MODE_NUMBER;
                start_next = pos_reg;
            end
            else if (punct[4])
            begin
                want = 1'b1;
                k    = {1'b0, punct[3:0]};
                s    = pos_ext[15:0];
                l    = 16'd1;
            end
            else
            begin
                mode_next  = dbt_pkg::MODE_IDENT;
                start_next = pos_reg;
                kbuf_next  = {40'd0, b};
            end

            // Append the new result, mark the final one of the word
            if (want)
            begin
                if (res.count == 2'd0)
                begin
                    res.count = 2'd1;
                    res.first = '{kind: k, start_res: s, length: l, last: 1'b1};
                end
                else
                begin
                    res.count  = 2'd2;
                    res.second = '{kind: k, start_res: s, length: l, last: 1'b1};
                end
            end
            else if (res.count == 2'd1)
                res.first.last = 1'b1;
        end
    end

    // Advance scan state on each accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= dbt_pkg::MODE_IDLE;
            pos_reg   <= '0;
            start_reg <= '0;
            kbuf_reg  <= '0;
        end
        else if (accept)
        begin
            mode_reg  <= mode_next;
            pos_reg   <= pos_next;
            start_reg <= start_next;
            kbuf_reg  <= kbuf_next;
        end
    end

endmodule

>>> rtl/core/dbt_tok_queue.sv
// Result queue: four token registers that take up to two results per cycle.
module dbt_tok_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  dbt_pkg::scan_res_t res,
    output logic               space,
    output logic               tok_valid,
    input  logic               tok_ready,
    output dbt_pkg::out_t      tok
);

    dbt_pkg::out_t entry_reg [4];
    logic [1:0]    wr_reg, wr_next;
    logic [1:0]    rd_reg, rd_next;
    logic [2:0]    cnt_reg, cnt_next;
    logic [1:0]    n_push;
    logic          pop;

    assign n_push    = push ? res.count : 2'd0;
    assign pop       = tok_valid && tok_ready;
    assign tok_valid = (cnt_reg != 3'd0);
    assign tok       = entry_reg[rd_reg];
    // Room for two more results
    assign space     = (cnt_reg <= 3'd2);

    assign wr_next  = wr_reg + n_push;
    assign rd_next  = rd_reg + {1'b0, pop};
    assign cnt_next = cnt_reg + {1'b0, n_push} - {2'b0, pop};

    // Write the results of a word at the tail
    always_ff @(posedge clk)
    begin
        if (n_push != 2'd0)
            entry_reg[wr_reg] <= res.first;
        if (n_push == 2'd2)
            entry_reg[wr_reg + 2'd1] <= res.second;
    end

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

>>> rtl/core/dsl_byte_tokenizer_top.sv
// A token enters the result queue registers when the source word that ends it is taken.
// Throughput: one source word per cycle while req_ready is high; a word gives zero, one or two tokens.
// A four-entry result queue feeds tok one token a cycle while tok_ready is high; req_ready drops while
// more than two tokens wait, so words that end two tokens in a row slow intake.
// Reset clears scan mode, offsets, keyword buffer and queue; no init sweep.
module dsl_byte_tokenizer_top #(
    parameter int POSITION_BITS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  dbt_pkg::in_t  req,
    output logic          tok_valid,
    input  logic          tok_ready,
    output dbt_pkg::out_t tok
);

    dbt_pkg::scan_res_t res;
    logic               accept;
    logic               space;

    assign req_ready = space;
    assign accept    = req_valid && req_ready;

    // Scan state and per-word results
    dbt_scan #(
        .POSITION_BITS (POSITION_BITS)
    ) u_scan (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .word   (req),
        .res    (res)
    );

    // Hold tokens until taken
    dbt_tok_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .res       (res),
        .space     (space),
        .tok_valid (tok_valid),
        .tok_ready (tok_ready),
        .tok       (tok)
    );

endmodule

>>> verif/tb_top.sv
// Self-checking testbench for the DSL byte tokenizer: directed table, random streams, scoreboard.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF        = 4;
    localparam int RESET_CYCLES    = 12;
    localparam int WORDS_PER_PHASE = 460;
    localparam int DRAIN_LIMIT     = 20000;
    localparam int TAIL_CYCLES     = 8;
    localparam int RUN_LIMIT_NS    = 8_000_000;
    localparam int EXP_DEPTH       = 64;
    localparam int DIR_DEPTH       = 32;

    // Punctuator kinds used in the directed table; the rest come from PUNCT_STR
    localparam logic [4:0] KIND_LPAREN = 5'd0;
    localparam logic [4:0] KIND_RPAREN = 5'd1;
    localparam logic [4:0] KIND_ASSIGN = 5'd11;
    localparam int         NUM_PUNCT   = 12;

    // Punctuator characters, kind 0 in the top byte
    localparam logic [8*NUM_PUNCT-1:0] PUNCT_STR = "(),<>:;{}[]=";
    localparam logic [8*63-1:0] WORD_CHARS =
        "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_";

    typedef struct packed {
        logic [47:0] spell;
        logic [2:0]  len;
        logic [4:0]  kind;
    } kw_t;

    typedef struct {
        dbt_pkg::in_t  word;
        int            n_typed;
        dbt_pkg::out_t t0;
        dbt_pkg::out_t t1;
    } dir_row_t;

    logic          clk = 1'b0;
    logic          rst_n;
    logic          req_valid;
    logic          req_ready;
    dbt_pkg::in_t  req;
    logic          tok_valid;
    logic          tok_ready;
    dbt_pkg::out_t tok;

    // Scanner state mirrored by the predictor
    dbt_pkg::mode_t scan_st;
    logic [15:0]    scan_pos;
    logic [15:0]    tok_start;
    logic [47:0]    kw_buf;

    // Expected tokens in arrival order, written at exp_wr and read at exp_rd
    dbt_pkg::out_t exp_toks [EXP_DEPTH];
    int            exp_wr     = 0;
    int            exp_rd     = 0;
    dir_row_t      directed_rows [DIR_DEPTH];
    int            n_rows     = 0;
    int            err_cnt    = 0;
    int            words_sent = 0;
    int            gap_pct    = 0;
    int            stall_pct  = 0;

    dsl_byte_tokenizer_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .tok_valid (tok_valid),
        .tok_ready (tok_ready),
        .tok       (tok)
    );

    always #(CLK_HALF) clk = ~clk;

    // ---------------------------------------------------------------
    // Character classes and keyword spellings
    // ---------------------------------------------------------------
    function automatic logic is_num_byte(input logic [7:0] b);
        return (b >= "0") && (b <= "9");
    endfunction

    function automatic logic is_word_byte(input logic [7:0] b);
        return is_num_byte(b) || ((b >= "a") && (b <= "z")) ||
               ((b >= "A") && (b <= "Z")) || (b == "_");
    endfunction

    function automatic logic is_blank(input logic [7:0] b);
        return (b == dbt_pkg::CH_SPACE) || (b == dbt_pkg::CH_TAB) || (b == dbt_pkg::CH_LF);
    endfunction

    // Index of b in the punctuator set, or -1
    function automatic int punct_index(input logic [7:0] b);
        for (int i = 0; i < NUM_PUNCT; i++)
            if (PUNCT_STR[8*(NUM_PUNCT-1-i) +: 8] == b)
                return i;
        return -1;
    endfunction

    function automatic kw_t keyword(input int i);
        case (i)
            0:       return '{spell: dbt_pkg::KW_FN,     len: 3'd2, kind: dbt_pkg::KIND_FN};
            1:       return '{spell: dbt_pkg::KW_LET,    len: 3'd3, kind: dbt_pkg::KIND_LET};
            2:       return '{spell: dbt_pkg::KW_TENSOR, len: 3'd6, kind: dbt_pkg::KIND_TENSOR};
            3:       return '{spell: dbt_pkg::KW_F32,    len: 3'd3, kind: dbt_pkg::KIND_F32};
            4:       return '{spell: dbt_pkg::KW_I32,    len: 3'd3, kind: dbt_pkg::KIND_I32};
            default: return '{spell: dbt_pkg::KW_CONST,  len: 3'd5, kind: dbt_pkg::KIND_CONST};
        endcase
    endfunction

    function automatic dbt_pkg::out_t tk(input logic [4:0] kind, input logic [15:0] start,
                                         input logic [15:0] len, input logic fin);
        return '{kind: kind, start_res: start, length: len, last: fin};
    endfunction

    // Append one token to the expected list
    function automatic void queue_tok(input dbt_pkg::out_t t);
        exp_toks[exp_wr % EXP_DEPTH] = t;
        exp_wr++;
    endfunction

    // ---------------------------------------------------------------
    // Token predictor
    // ---------------------------------------------------------------
    function automatic void clear_scanner();
        scan_st   = dbt_pkg::MODE_IDLE;
        scan_pos  = '0;
        tok_start = '0;
        kw_buf    = '0;
    endfunction

    // Feed one source word; return the number of tokens it finishes
    function automatic int tokenize_byte(input dbt_pkg::in_t w, output dbt_pkg::out_t r0,
                                         output dbt_pkg::out_t r1);
        logic [7:0]    b;
        logic          stop;
        logic [15:0]   span;
        logic [4:0]    kind;
        dbt_pkg::out_t res [2];
        int            n;
        int            pi;
        kw_t           kw;
        b    = w.byte_req;
        stop = w.end_of_input || (b == dbt_pkg::CH_NUL);
        n    = 0;
        r0   = '0;
        r1   = '0;
        res[0] = '0;
        res[1] = '0;

        // swallow comment body up to newline
        if (scan_st == dbt_pkg::MODE_COMMENT)
        begin
            if (!stop)
            begin
                if (b == dbt_pkg::CH_LF)
                    scan_st = dbt_pkg::MODE_IDLE;
                scan_pos++;
                return 0;
            end
            scan_st = dbt_pkg::MODE_IDLE;
        end

        // resolve a pending dash: comment, arrow or identifier
        if (scan_st == dbt_pkg::MODE_DASH)
        begin
            if (!stop && b == dbt_pkg::CH_DASH)
            begin
                scan_st = dbt_pkg::MODE_COMMENT;
                scan_pos++;
                return 0;
            end
            if (!stop && b == dbt_pkg::CH_GT)
            begin
                r0 = tk(dbt_pkg::KIND_ARROW, tok_start, 16'd2, 1'b1);
                scan_st = dbt_pkg::MODE_IDLE;
                scan_pos++;
                return 1;
            end
            scan_st = dbt_pkg::MODE_IDENT;
        end

        span = scan_pos - tok_start;
        if (scan_st == dbt_pkg::MODE_IDENT)
        begin
            if (!stop && is_word_byte(b))
            begin
                kw_buf = {kw_buf[39:0], b};
                scan_pos++;
                return 0;
            end
            kind = dbt_pkg::KIND_IDENT;
            if (span <= 16'd6)
                for (int i = 0; i < 6; i++)
                begin
                    kw = keyword(i);
                    if (span == 16'(kw.len) && kw_buf == kw.spell)
                        kind = kw.kind;
                end
            res[n] = tk(kind, tok_start, span, 1'b0);
            n++;
            scan_st = dbt_pkg::MODE_IDLE;
        end
        else if (scan_st == dbt_pkg::MODE_NUMBER)
        begin
            if (!stop && (is_num_byte(b) || b == "."))
            begin
                scan_pos++;
                return 0;
            end
            res[n] = tk(dbt_pkg::KIND_NUMBER, tok_start, span, 1'b0);
            n++;
            scan_st = dbt_pkg::MODE_IDLE;
        end

        // handle the word on its own
        if (stop)
        begin
            res[n] = tk(dbt_pkg::KIND_EOF, scan_pos, 16'd0, 1'b0);
            n++;
            clear_scanner();
        end
        else if (!is_blank(b))
        begin
            pi = punct_index(b);
            if (b == dbt_pkg::CH_DASH)
            begin
                scan_st   = dbt_pkg::MODE_DASH;
                tok_start = scan_pos;
                kw_buf    = {40'd0, b};
            end
            else if (is_num_byte(b))
            begin
                scan_st   = dbt_pkg::MODE_NUMBER;
                tok_start = scan_pos;
            end
            else if (pi >= 0)
            begin
                res[n] = tk(5'(pi), scan_pos, 16'd1, 1'b0);
                n++;
            end
            else
            begin
                scan_st   = dbt_pkg::MODE_IDENT;
                tok_start = scan_pos;
                kw_buf    = {40'd0, b};
            end
        end
        if (!stop)
            scan_pos++;

        if (n > 0)
            res[n-1].last = 1'b1;
        r0 = res[0];
        r1 = res[1];
        return n;
    endfunction

    // ---------------------------------------------------------------
    // Source side: drive at falling edge, accept at rising edge
    // ---------------------------------------------------------------
    task automatic send_word(input dbt_pkg::in_t w, input int n_typed,
                             input dbt_pkg::out_t t0, input dbt_pkg::out_t t1);
        dbt_pkg::out_t p0;
        dbt_pkg::out_t p1;
        int            n;
        // idle before the word
        while ($urandom_range(99) < gap_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req       <= w;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (!req_ready);

        // predictor always advances; typed rows override its tokens
        n = tokenize_byte(w, p0, p1);
        if (n_typed >= 0)
        begin
            n  = n_typed;
            p0 = t0;
            p1 = t1;
        end
        if (n > 0)
            queue_tok(p0);
        if (n > 1)
            queue_tok(p1);
        words_sent++;
        @(negedge clk);
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_word({b, 1'b0}, -1, '0, '0);
    endtask

    function automatic void add_row(input logic [7:0] b, input logic eoi, input int n,
                                    input dbt_pkg::out_t t0, input dbt_pkg::out_t t1);
        dir_row_t r;
        r.word    = {b, eoi};
        r.n_typed = n;
        r.t0      = t0;
        r.t1      = t1;
        directed_rows[n_rows] = r;
        n_rows++;
    endfunction

    // Random identifier start: anything that is not blank, dash, digit, punctuator or NUL
    function automatic logic [7:0] odd_start();
        logic [7:0] b;
        do
            b = 8'($urandom_range(1, 255));
        while (is_blank(b) || b == dbt_pkg::CH_DASH || is_num_byte(b) || punct_index(b) >= 0);
        return b;
    endfunction

    function automatic logic [7:0] word_char();
        return WORD_CHARS[8*$urandom_range(62) +: 8];
    endfunction

    // One well-formed-ish stream of tokens, ended by NUL or end of input
    task automatic random_stream();
        int         ntok;
        int         sel;
        int         cnt;
        kw_t        kw;
        logic [7:0] b;
        ntok = $urandom_range(1, 24);
        for (int t = 0; t < ntok; t++)
        begin
            sel = $urandom_range(99);
            if (sel < 8)
                send_byte(8'($urandom_range(1, 255)));
            else if (sel < 30)
            begin
                // keyword, sometimes with a prefix or a suffix so it reads as an identifier
                kw = keyword($urandom_range(5));
                if ($urandom_range(9) == 0)
                    send_byte(word_char());
                for (int i = int'(kw.len) - 1; i >= 0; i--)
                    send_byte(kw.spell[8*i +: 8]);
                if ($urandom_range(9) == 0)
                    send_byte(word_char());
            end
            else if (sel < 48)
            begin
                send_byte(($urandom_range(3) == 0) ? odd_start() : "q");
                cnt = $urandom_range(0, 8);
                for (int i = 0; i < cnt; i++)
                    send_byte(word_char());
            end
            else if (sel < 60)
            begin
                send_byte(8'("0" + $urandom_range(9)));
                cnt = $urandom_range(0, 5);
                for (int i = 0; i < cnt; i++)
                    send_byte(($urandom_range(3) == 0) ? "." : 8'("0" + $urandom_range(9)));
            end
            else if (sel < 78)
                send_byte(PUNCT_STR[8*$urandom_range(NUM_PUNCT-1) +: 8]);
            else if (sel < 84)
            begin
                send_byte(dbt_pkg::CH_DASH);
                send_byte(dbt_pkg::CH_GT);
            end
            else if (sel < 88)
                send_byte(dbt_pkg::CH_DASH);
            else if (sel < 94)
            begin
                send_byte(dbt_pkg::CH_DASH);
                send_byte(dbt_pkg::CH_DASH);
                cnt = $urandom_range(0, 6);
                for (int i = 0; i < cnt; i++)
                begin
                    do
                        b = 8'($urandom_range(1, 255));
                    while (b == dbt_pkg::CH_LF);
                    send_byte(b);
                end
                send_byte(dbt_pkg::CH_LF);
            end
            else
            begin
                cnt = $urandom_range(1, 4);
                for (int i = 0; i < cnt; i++)
                    send_byte(($urandom_range(1) == 0) ? dbt_pkg::CH_SPACE : dbt_pkg::CH_TAB);
            end

            // separator or none, so tokens also abut
            sel = $urandom_range(9);
            if (sel < 3)
                send_byte(dbt_pkg::CH_SPACE);
            else if (sel < 5)
                send_byte(dbt_pkg::CH_LF);
            else if (sel < 6)
                send_byte(dbt_pkg::CH_TAB);
        end

        // comment left open at end of stream
        if ($urandom_range(9) == 0)
        begin
            send_byte(dbt_pkg::CH_DASH);
            send_byte(dbt_pkg::CH_DASH);
            send_byte(word_char());
        end

        sel = $urandom_range(9);
        if (sel < 4)
            send_word({8'($urandom_range(255)), 1'b1}, -1, '0, '0);
        else if (sel < 8)
            send_byte(dbt_pkg::CH_NUL);
        else
            send_word({dbt_pkg::CH_NUL, 1'b1}, -1, '0, '0);
    endtask

    // ---------------------------------------------------------------
    // Sink side: random stall, compare accepted tokens in order
    // ---------------------------------------------------------------
    always @(negedge clk)
        tok_ready <= ($urandom_range(99) >= stall_pct);

    task automatic check_field(input string name, input int unsigned exp_v,
                               input int unsigned act_v);
        if (exp_v != act_v)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
            err_cnt++;
        end
    endtask

    always @(posedge clk)
    begin : tok_monitor
        dbt_pkg::out_t want;
        if (rst_n && tok_valid && tok_ready)
        begin
            if (exp_wr == exp_rd)
            begin
                $error("token with none expected: kind %0d start %0d length %0d",
                       tok.kind, tok.start_res, tok.length);
                err_cnt++;
            end
            else
            begin
                want = exp_toks[exp_rd % EXP_DEPTH];
                exp_rd++;
                check_field("kind", want.kind, tok.kind);
                check_field("start_res", want.start_res, tok.start_res);
                check_field("length", want.length, tok.length);
                check_field("last", want.last, tok.last);
            end
        end
    end

    // ---------------------------------------------------------------
    // Run guard
    // ---------------------------------------------------------------
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("DONE: errors detected");
        $finish;
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    initial
    begin
        int drain;
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        tok_ready = 1'b0;
        clear_scanner();

        // Stream: punctuators, arrow, keyword, number ending on a punctuator,
        // comment closed by newline, dash-led identifier closed by end of input
        add_row("(",              1'b0, 1, tk(KIND_LPAREN, 16'd0, 16'd1, 1'b1), '0);
        add_row("=",              1'b0, 1, tk(KIND_ASSIGN, 16'd1, 16'd1, 1'b1), '0);
        add_row(dbt_pkg::CH_DASH, 1'b0, 0, '0, '0);
        add_row(dbt_pkg::CH_GT,   1'b0, 1, tk(dbt_pkg::KIND_ARROW, 16'd2, 16'd2, 1'b1), '0);
        add_row("f",              1'b0, -1, '0, '0);
        add_row("n",              1'b0, -1, '0, '0);
        add_row(dbt_pkg::CH_TAB,  1'b0, 1, tk(dbt_pkg::KIND_FN, 16'd4, 16'd2, 1'b1), '0);
        add_row("9",              1'b0, -1, '0, '0);
        add_row(".",              1'b0, -1, '0, '0);
        add_row(")",              1'b0, 2, tk(dbt_pkg::KIND_NUMBER, 16'd7, 16'd2, 1'b0),
                                           tk(KIND_RPAREN, 16'd9, 16'd1, 1'b1));
        add_row(dbt_pkg::CH_DASH, 1'b0, -1, '0, '0);
        add_row(dbt_pkg::CH_DASH, 1'b0, -1, '0, '0);
        add_row("x",              1'b0, -1, '0, '0);
        add_row(dbt_pkg::CH_LF,   1'b0, -1, '0, '0);
        add_row(dbt_pkg::CH_DASH, 1'b0, -1, '0, '0);
        add_row("a",              1'b0, -1, '0, '0);
        add_row("(",              1'b1, 2, tk(dbt_pkg::KIND_IDENT, 16'd14, 16'd2, 1'b0),
                                           tk(dbt_pkg::KIND_EOF, 16'd16, 16'd0, 1'b1));
        // Stream: lone dash cut by a high byte, which starts an identifier; NUL ends
        add_row(dbt_pkg::CH_DASH, 1'b0, -1, '0, '0);
        add_row(8'hFF,            1'b0, 1, tk(dbt_pkg::KIND_IDENT, 16'd0, 16'd1, 1'b1), '0);
        add_row("x",              1'b0, -1, '0, '0);
        add_row(dbt_pkg::CH_NUL,  1'b0, 2, tk(dbt_pkg::KIND_IDENT, 16'd1, 16'd2, 1'b0),
                                           tk(dbt_pkg::KIND_EOF, 16'd3, 16'd0, 1'b1));
        // Stream: comment still open at end of input
        add_row(dbt_pkg::CH_DASH, 1'b0, -1, '0, '0);
        add_row(dbt_pkg::CH_DASH, 1'b0, -1, '0, '0);
        add_row(8'hFF,            1'b1, 1, tk(dbt_pkg::KIND_EOF, 16'd2, 16'd0, 1'b1), '0);

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    gap_pct   = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    gap_pct   = 50;
                    stall_pct = 0;
                end
                2:
                begin
                    gap_pct   = 0;
                    stall_pct = 50;
                end
                default:
                begin
                    gap_pct   = 15;
                    stall_pct = 15;
                end
            endcase

            if (ph == 0)
            begin
                for (int i = 0; i < n_rows; i++)
                    send_word(directed_rows[i].word, directed_rows[i].n_typed,
                              directed_rows[i].t0, directed_rows[i].t1);
            end

            while (words_sent < (ph + 1) * WORDS_PER_PHASE)
                random_stream();
        end
        req_valid <= 1'b0;

        // Drain outstanding tokens, then let the pipeline settle
        drain = 0;
        while (exp_wr != exp_rd && drain < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        if (exp_wr != exp_rd)
        begin
            $error("%0d expected tokens never arrived", exp_wr - exp_rd);
            err_cnt++;
        end

        if (err_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/dbt_pkg.sv
rtl/core/dbt_scan.sv
rtl/core/dbt_tok_queue.sv
rtl/core/dsl_byte_tokenizer_top.sv
verif/tb_top.sv
